/* src/crsq_pkg.sv */
// Shared types and codes of the coalescing retry send queue.
package crsq_pkg;

	localparam int CMD_W  = 8;
	localparam int TEMP_W = 11;
	localparam int CNT3_W = 3;

	typedef enum logic [1:0] {
		KIND_PUSH  = 2'd0,
		KIND_DONE  = 2'd1,
		KIND_FAIL  = 2'd2,
		KIND_TIMER = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ACT_SEND       = 2'd0,
		ACT_RETRY_WAIT = 2'd1,
		ACT_DROPPED    = 2'd2
	} action_t;

	localparam logic [1:0] CFG_STATUS_CODE   = 2'd0;
	localparam logic [1:0] CFG_POSITION_CODE = 2'd1;
	localparam logic [1:0] CFG_RETRY_LIMIT   = 2'd2;

	// Result request from the sequencer to the output register.
	typedef struct packed {
		logic    valid;
		action_t action;
		logic    gave;
	} emit_req_t;

endpackage

/* src/crsq_store.sv */
// Entry storage: one write port, one indexed read port, fixed head read.
module crsq_store #(
	parameter int QUEUE_DEPTH = 4,
	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
	input  logic                                 clk,
	input  logic                                 wr_en,
	input  logic                                 wr_cmd_only,
	input  logic [IDX_W-1:0]                     wr_idx,
	input  logic [crsq_pkg::CMD_W-1:0]           wr_cmd,
	input  logic signed [crsq_pkg::TEMP_W-1:0]   wr_temp,
	input  logic [IDX_W-1:0]                     rd_idx,
	output logic [crsq_pkg::CMD_W-1:0]           rd_cmd,
	output logic signed [crsq_pkg::TEMP_W-1:0]   rd_temp,
	output logic [crsq_pkg::CMD_W-1:0]           head_cmd,
	output logic signed [crsq_pkg::TEMP_W-1:0]   head_temp
);

	logic [crsq_pkg::CMD_W-1:0]         cmd_q  [QUEUE_DEPTH];
	logic signed [crsq_pkg::TEMP_W-1:0] temp_q [QUEUE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			cmd_q[wr_idx] <= wr_cmd;
			if (!wr_cmd_only) begin
				temp_q[wr_idx] <= wr_temp;
			end
		end
	end

	assign rd_cmd    = cmd_q[rd_idx];
	assign rd_temp   = temp_q[rd_idx];
	assign head_cmd  = cmd_q[0];
	assign head_temp = temp_q[0];

endmodule

/* src/crsq_seq.sv */
// Sequencer: decodes one event, scans / appends / shifts entries with a shared compare.
module crsq_seq #(
	parameter int QUEUE_DEPTH = 4,
	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [1:0]                           kind,
	input  logic [crsq_pkg::CMD_W-1:0]           command,
	input  logic signed [crsq_pkg::TEMP_W-1:0]   temperature,
	input  logic [crsq_pkg::CMD_W-1:0]           status_code,
	input  logic [crsq_pkg::CMD_W-1:0]           position_code,
	input  logic [crsq_pkg::CNT3_W-1:0]          retry_limit,
	input  logic                                 out_free,
	output crsq_pkg::emit_req_t                  emit,
	output logic [crsq_pkg::CNT3_W-1:0]          retry,
	output logic [CNT_W-1:0]                     count,
	output logic                                 wr_en,
	output logic                                 wr_cmd_only,
	output logic [IDX_W-1:0]                     wr_idx,
	output logic [crsq_pkg::CMD_W-1:0]           wr_cmd,
	output logic signed [crsq_pkg::TEMP_W-1:0]   wr_temp,
	output logic [IDX_W-1:0]                     rd_idx,
	input  logic [crsq_pkg::CMD_W-1:0]           rd_cmd,
	input  logic signed [crsq_pkg::TEMP_W-1:0]   rd_temp
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_CHECK  = 6'b000010,
		ST_SCAN   = 6'b000100,
		ST_APPEND = 6'b001000,
		ST_SHIFT  = 6'b010000,
		ST_EMIT   = 6'b100000
	} state_t;

	state_t                             state_q, state_d;
	crsq_pkg::kind_t                    kind_q;
	logic [crsq_pkg::CMD_W-1:0]         cmd_q;
	logic signed [crsq_pkg::TEMP_W-1:0] temp_q;
	logic [IDX_W-1:0]                   ptr_q, ptr_d;
	logic [CNT_W-1:0]                   count_q, count_d;
	logic [crsq_pkg::CNT3_W-1:0]        retry_q, retry_d;
	crsq_pkg::action_t                  action_q, action_d;
	logic                               gave_q, gave_d;

	logic [CNT_W-1:0]           ptr_nx;
	logic [crsq_pkg::CMD_W-1:0] cmp_code;
	logic                       is_req;

	// shared request-code comparator
	assign cmp_code = (state_q == ST_SCAN) ? rd_cmd : cmd_q;
	assign is_req   = (cmp_code == status_code) || (cmp_code == position_code);
	assign ptr_nx   = CNT_W'(ptr_q) + CNT_W'(1);

	always_comb begin
		state_d     = state_q;
		ptr_d       = ptr_q;
		count_d     = count_q;
		retry_d     = retry_q;
		action_d    = action_q;
		gave_d      = gave_q;
		wr_en       = 1'b0;
		wr_cmd_only = 1'b0;
		wr_idx      = ptr_q;
		wr_cmd      = cmd_q;
		wr_temp     = temp_q;
		rd_idx      = ptr_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				ptr_d    = '0;
				gave_d   = 1'b0;
				action_d = crsq_pkg::ACT_SEND;
				unique case (kind_q)
					crsq_pkg::KIND_PUSH: begin
						state_d = (is_req && count_q != '0) ? ST_SCAN : ST_APPEND;
					end
					crsq_pkg::KIND_DONE: begin
						retry_d = '0;
						state_d = (count_q == '0) ? ST_IDLE : ST_SHIFT;
					end
					crsq_pkg::KIND_FAIL: begin
						if (count_q == '0) begin
							state_d = ST_IDLE;
						end else if (retry_q >= retry_limit) begin
							retry_d = '0;
							gave_d  = 1'b1;
							state_d = ST_SHIFT;
						end else begin
							retry_d  = retry_q + 3'd1;
							action_d = crsq_pkg::ACT_RETRY_WAIT;
							state_d  = ST_EMIT;
						end
					end
					crsq_pkg::KIND_TIMER: begin
						state_d = (count_q == '0) ? ST_IDLE : ST_EMIT;
					end
					default: state_d = ST_IDLE;
				endcase
			end
			ST_SCAN: begin
				if (is_req) begin
					// coalesce: overwrite the command, keep the temperature
					wr_en       = 1'b1;
					wr_cmd_only = 1'b1;
					state_d     = ST_IDLE;
				end else if (ptr_nx == count_q) begin
					state_d = ST_APPEND;
				end else begin
					ptr_d = ptr_nx[IDX_W-1:0];
				end
			end
			ST_APPEND: begin
				if (count_q >= CNT_W'(QUEUE_DEPTH)) begin
					action_d = crsq_pkg::ACT_DROPPED;
					state_d  = ST_EMIT;
				end else begin
					wr_en   = 1'b1;
					wr_idx  = count_q[IDX_W-1:0];
					count_d = count_q + CNT_W'(1);
					if (count_q == '0) begin
						retry_d = '0;
						state_d = ST_EMIT;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_SHIFT: begin
				rd_idx = ptr_nx[IDX_W-1:0];
				if (ptr_nx < count_q) begin
					wr_en   = 1'b1;
					wr_cmd  = rd_cmd;
					wr_temp = rd_temp;
					ptr_d   = ptr_nx[IDX_W-1:0];
				end else begin
					count_d = count_q - CNT_W'(1);
					state_d = (count_q > CNT_W'(1)) ? ST_EMIT : ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			retry_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			retry_q <= retry_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			kind_q <= crsq_pkg::kind_t'(kind);
			cmd_q  <= command;
			temp_q <= temperature;
		end
		ptr_q    <= ptr_d;
		action_q <= action_d;
		gave_q   <= gave_d;
	end

	assign in_stall    = (state_q != ST_IDLE);
	assign emit.valid  = (state_q == ST_EMIT);
	assign emit.action = action_q;
	assign emit.gave   = gave_q;
	assign retry       = retry_q;
	assign count       = count_q;

endmodule

/* src/coalescing_retry_send_queue_top.sv */
// Top level of the coalescing retry send queue: config registers, output register.
//
// - Input channel (in_valid / in_stall; kind, command, temperature): one event
//   per transaction: push a command, send done, send failed, retry timer expired.
// - Output channel (out_valid / out_stall; action ... gave_up): at most one
//   result per event: send the head, start a retry wait, or push dropped.
// - Config port (cfg_wr_en, cfg_index, cfg_data): write only while idle.
//   Index 0 status request code, 1 position request code, 2 retry limit.
// - One event at a time; a shared code comparator scans entries one per cycle
//   and a removal moves entries one per cycle. in_stall stays high while the
//   sequencer works on an event, including any wait in the emit step; the next
//   event is taken in the first cycle in_stall is low.
// - A result appears on out_valid in the cycle after the emit step loads it.
// - arst_n clears the queue, the retry count and the output register and
//   restores the config defaults. Entry storage is not cleared.
// - While out_stall holds a result, the next event is still accepted and only
//   waits in its emit step if it has a result to post.
module coalescing_retry_send_queue_top #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [1:0]                           kind,
	input  logic [crsq_pkg::CMD_W-1:0]           command,
	input  logic signed [crsq_pkg::TEMP_W-1:0]   temperature,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [1:0]                           action,
	output logic [crsq_pkg::CMD_W-1:0]           send_command,
	output logic [9:0]                           send_temperature,
	output logic                                 temperature_present,
	output logic [crsq_pkg::CNT3_W-1:0]          attempts_so_far,
	output logic [crsq_pkg::CNT3_W-1:0]          queue_level,
	output logic                                 gave_up,
	input  logic                                 cfg_wr_en,
	input  logic [1:0]                           cfg_index,
	input  logic [crsq_pkg::CMD_W-1:0]           cfg_data
);

	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	// config registers
	logic [crsq_pkg::CMD_W-1:0]  status_code_q;
	logic [crsq_pkg::CMD_W-1:0]  position_code_q;
	logic [crsq_pkg::CNT3_W-1:0] retry_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_code_q   <= 8'd0;
			position_code_q <= 8'd1;
			retry_limit_q   <= 3'd5;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				crsq_pkg::CFG_STATUS_CODE:   status_code_q   <= cfg_data;
				crsq_pkg::CFG_POSITION_CODE: position_code_q <= cfg_data;
				crsq_pkg::CFG_RETRY_LIMIT:   retry_limit_q   <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	crsq_pkg::emit_req_t                emit;
	logic [crsq_pkg::CNT3_W-1:0]        retry;
	logic [CNT_W-1:0]                   count;
	logic                               wr_en, wr_cmd_only;
	logic [IDX_W-1:0]                   wr_idx, rd_idx;
	logic [crsq_pkg::CMD_W-1:0]         wr_cmd, rd_cmd, head_cmd;
	logic signed [crsq_pkg::TEMP_W-1:0] wr_temp, rd_temp, head_temp;
	logic                               out_free, load;

	crsq_store #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_store (
		.clk         (clk),
		.wr_en       (wr_en),
		.wr_cmd_only (wr_cmd_only),
		.wr_idx      (wr_idx),
		.wr_cmd      (wr_cmd),
		.wr_temp     (wr_temp),
		.rd_idx      (rd_idx),
		.rd_cmd      (rd_cmd),
		.rd_temp     (rd_temp),
		.head_cmd    (head_cmd),
		.head_temp   (head_temp)
	);

	crsq_seq #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.kind          (kind),
		.command       (command),
		.temperature   (temperature),
		.status_code   (status_code_q),
		.position_code (position_code_q),
		.retry_limit   (retry_limit_q),
		.out_free      (out_free),
		.emit          (emit),
		.retry         (retry),
		.count         (count),
		.wr_en         (wr_en),
		.wr_cmd_only   (wr_cmd_only),
		.wr_idx        (wr_idx),
		.wr_cmd        (wr_cmd),
		.wr_temp       (wr_temp),
		.rd_idx        (rd_idx),
		.rd_cmd        (rd_cmd),
		.rd_temp       (rd_temp)
	);

	// output register: free when empty or being taken this cycle
	logic                        out_valid_q;
	logic [1:0]                  action_q;
	logic [crsq_pkg::CMD_W-1:0]  send_command_q;
	logic [9:0]                  send_temperature_q;
	logic                        temperature_present_q;
	logic [crsq_pkg::CNT3_W-1:0] attempts_q;
	logic [crsq_pkg::CNT3_W-1:0] level_q;
	logic                        gave_up_q;

	assign out_free = !out_valid_q || !out_stall;
	assign load     = emit.valid && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// a negative temperature (sign bit set) means none
	always_ff @(posedge clk) begin
		if (load) begin
			action_q              <= emit.action;
			send_command_q        <= head_cmd;
			temperature_present_q <= !head_temp[crsq_pkg::TEMP_W-1];
			send_temperature_q    <= head_temp[crsq_pkg::TEMP_W-1] ? 10'd0 : head_temp[9:0];
			attempts_q            <= retry;
			level_q               <= crsq_pkg::CNT3_W'(count);
			gave_up_q             <= emit.gave;
		end
	end

	assign out_valid           = out_valid_q;
	assign action              = action_q;
	assign send_command        = send_command_q;
	assign send_temperature    = send_temperature_q;
	assign temperature_present = temperature_present_q;
	assign attempts_so_far     = attempts_q;
	assign queue_level         = level_q;
	assign gave_up             = gave_up_q;

	// queue never holds more than its depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count above depth");

	// a dropped push is only reported on a full queue
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && action == crsq_pkg::ACT_DROPPED)
			|-> (queue_level == crsq_pkg::CNT3_W'(QUEUE_DEPTH)))
		else $error("dropped push with queue not full");

	// a reported give-up always comes with a send of the next head
	a_gave_send: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && gave_up) |-> (action == crsq_pkg::ACT_SEND && attempts_so_far == 3'd0))
		else $error("give-up without send of next head");

	// new events are taken only when no result is pending in the sequencer
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !emit.valid)
		else $error("event accepted while a result is pending");

endmodule

/* tb/sv/coalescing_retry_send_queue_top_tb.sv */
// Self-checking testbench for the coalescing retry send queue top level.
`timescale 1ns / 100ps

module coalescing_retry_send_queue_top_tb;

	localparam int QUEUE_DEPTH      = 4;
	localparam int RESET_CYCLES     = 8;
	// Longest event is a full scan plus the output register; pad it well.
	localparam int SETTLE_CYCLES    = 16;
	localparam int RANDOM_PER_PHASE = 220;
	localparam int PHASES           = 5;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int DRAIN_LIMIT      = 5000;
	localparam int CYCLE_LIMIT      = 500000;

	// One result transaction as the output port shows it.
	typedef struct packed {
		crsq_pkg::action_t act;
		logic [7:0]        cmd;
		logic [9:0]        temp;
		logic              present;
		logic [2:0]        attempts;
		logic [2:0]        level;
		logic              gave;
	} send_result_t;

	// How a stimulus row is checked: against the predictor, or by hand.
	typedef enum logic [1:0] {
		ROW_PREDICT,
		ROW_NO_RESULT,
		ROW_RESULT
	} row_check_t;

	typedef struct packed {
		crsq_pkg::kind_t    k;
		logic [7:0]         cmd;
		logic signed [10:0] temp;
		row_check_t         chk;
		send_result_t       res;
	} event_row_t;

	// DUT ports; every input has a known value from time zero.
	logic                               clk         = 1'b0;
	logic                               arst_n      = 1'b0;
	logic                               in_valid    = 1'b0;
	logic                               in_stall;
	logic [1:0]                         kind        = crsq_pkg::KIND_PUSH;
	logic [crsq_pkg::CMD_W-1:0]         command     = '0;
	logic signed [crsq_pkg::TEMP_W-1:0] temperature = '0;
	logic                               out_valid;
	logic                               out_stall   = 1'b0;
	logic [1:0]                         action;
	logic [crsq_pkg::CMD_W-1:0]         send_command;
	logic [9:0]                         send_temperature;
	logic                               temperature_present;
	logic [crsq_pkg::CNT3_W-1:0]        attempts_so_far;
	logic [crsq_pkg::CNT3_W-1:0]        queue_level;
	logic                               gave_up;
	logic                               cfg_wr_en   = 1'b0;
	logic [1:0]                         cfg_index   = crsq_pkg::CFG_STATUS_CODE;
	logic [crsq_pkg::CMD_W-1:0]         cfg_data    = '0;

	// Predictor copy of the queue and of the config registers (reset values).
	logic [7:0]         q_cmd  [QUEUE_DEPTH];
	logic signed [10:0] q_temp [QUEUE_DEPTH];
	int unsigned        q_count       = 0;
	logic [2:0]         retries       = '0;
	logic [7:0]         status_code   = 8'd0;
	logic [7:0]         position_code = 8'd1;
	logic [2:0]         retry_max     = 3'd5;

	send_result_t pending_results[$];
	event_row_t   directed_rows[$];

	// Register settings per random phase; the last one is drawn at run time.
	logic [7:0] phase_status   [PHASES] = '{8'h10, 8'hFF, 8'h33, 8'h00, 8'h00};
	logic [7:0] phase_position [PHASES] = '{8'h20, 8'h00, 8'h33, 8'hFF, 8'h00};
	logic [2:0] phase_limit    [PHASES] = '{3'd0, 3'd7, 3'd1, 3'd3, 3'd0};

	int unsigned errors          = 0;
	int unsigned cycle_count     = 0;
	int unsigned events_accepted = 0;
	int unsigned results_checked = 0;
	int unsigned dropped_seen    = 0;
	int unsigned gave_up_seen    = 0;
	int unsigned burst_left      = 0;
	bit          offering        = 1'b0;
	bit          hold_request    = 1'b0;

	coalescing_retry_send_queue_top #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.kind               (kind),
		.command            (command),
		.temperature        (temperature),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.action             (action),
		.send_command       (send_command),
		.send_temperature   (send_temperature),
		.temperature_present(temperature_present),
		.attempts_so_far    (attempts_so_far),
		.queue_level        (queue_level),
		.gave_up            (gave_up),
		.cfg_wr_en          (cfg_wr_en),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic bit is_request(input logic [7:0] c);
		return (c == status_code) || (c == position_code);
	endfunction

	// Result built from the current head entry; absent temperature reads as 0.
	function automatic send_result_t head_result(input crsq_pkg::action_t a,
			input logic gave);
		send_result_t r;
		r.act      = a;
		r.cmd      = q_cmd[0];
		r.present  = ~q_temp[0][10];
		r.temp     = r.present ? q_temp[0][9:0] : 10'd0;
		r.attempts = retries;
		r.level    = 3'(q_count);
		r.gave     = gave;
		return r;
	endfunction

	// Head leaves (done or give-up); the next one is sent if there is one.
	function automatic bit advance_queue(input logic gave, output send_result_t r);
		r = '0;
		if (q_count != 0) begin
			for (int i = 0; i + 1 < q_count; i++) begin
				q_cmd[i]  = q_cmd[i + 1];
				q_temp[i] = q_temp[i + 1];
			end
			q_count--;
		end
		retries = '0;
		if (q_count == 0)
			return 1'b0;
		r = head_result(crsq_pkg::ACT_SEND, gave);
		return 1'b1;
	endfunction

	// Applies one event to the predictor state; returns 1 when a result is due.
	function automatic bit next_send_result(input crsq_pkg::kind_t k,
			input logic [7:0] c, input logic signed [10:0] t, output send_result_t r);
		bit started_empty;
		r = '0;
		started_empty = (q_count == 0);
		case (k)
			crsq_pkg::KIND_PUSH: begin
				// Requests collapse into any request already waiting,
				// keeping that entry's temperature.
				if (is_request(c)) begin
					for (int i = 0; i < q_count; i++) begin
						if (is_request(q_cmd[i])) begin
							q_cmd[i] = c;
							return 1'b0;
						end
					end
				end
				if (q_count >= QUEUE_DEPTH) begin
					r = head_result(crsq_pkg::ACT_DROPPED, 1'b0);
					return 1'b1;
				end
				q_cmd[q_count]  = c;
				q_temp[q_count] = t;
				q_count++;
				if (!started_empty)
					return 1'b0;
				retries = '0;
				r = head_result(crsq_pkg::ACT_SEND, 1'b0);
				return 1'b1;
			end
			crsq_pkg::KIND_DONE:
				return advance_queue(1'b0, r);
			crsq_pkg::KIND_FAIL: begin
				if (started_empty)
					return 1'b0;
				if (retries >= retry_max)
					return advance_queue(1'b1, r);
				retries++;
				r = head_result(crsq_pkg::ACT_RETRY_WAIT, 1'b0);
				return 1'b1;
			end
			default: begin
				if (started_empty)
					return 1'b0;
				r = head_result(crsq_pkg::ACT_SEND, 1'b0);
				return 1'b1;
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic send_result_t mk_result(input crsq_pkg::action_t a,
			input logic [7:0] c, input int t, input logic p, input int att,
			input int lvl, input logic g);
		send_result_t r;
		r.act      = a;
		r.cmd      = c;
		r.temp     = 10'(t);
		r.present  = p;
		r.attempts = 3'(att);
		r.level    = 3'(lvl);
		r.gave     = g;
		return r;
	endfunction

	task automatic add_row(input crsq_pkg::kind_t k, input logic [7:0] c, input int t,
			input row_check_t chk, input send_result_t res);
		event_row_t row;
		row.k    = k;
		row.cmd  = c;
		row.temp = 11'(t);
		row.chk  = chk;
		row.res  = res;
		directed_rows.push_back(row);
	endtask

	// Random event: request codes are favored so that coalescing happens often.
	function automatic event_row_t random_event(input int unsigned push_pct);
		event_row_t  row;
		int unsigned sel;
		row.chk = ROW_PREDICT;
		row.res = '0;
		if ($urandom_range(99) < push_pct) begin
			row.k = crsq_pkg::KIND_PUSH;
		end else begin
			sel = $urandom_range(99);
			row.k = (sel < 35) ? crsq_pkg::KIND_DONE
				: (sel < 75) ? crsq_pkg::KIND_FAIL : crsq_pkg::KIND_TIMER;
		end
		sel = $urandom_range(9);
		row.cmd = (sel < 3) ? status_code : (sel < 5) ? position_code
			: 8'($urandom_range(255));
		sel = $urandom_range(9);
		row.temp = (sel < 2) ? -11'sd1 : (sel == 2) ? 11'sd999 : (sel == 3) ? 11'sd0
			: 11'($urandom_range(999));
		return row;
	endfunction

	task automatic release_input();
		if (offering) begin
			in_valid <= 1'b0;
			offering = 1'b0;
		end
	endtask

	// Offers one transaction and holds it until accepted. Valid stays up for a
	// following transaction unless the caller releases it.
	task automatic offer(input event_row_t row);
		send_result_t r;
		bit           has_r;
		offering = 1'b1;
		in_valid    <= 1'b1;
		kind        <= row.k;
		command     <= row.cmd;
		temperature <= row.temp;
		do @(posedge clk); while (in_stall !== 1'b0);
		has_r = next_send_result(row.k, row.cmd, row.temp, r);
		case (row.chk)
			ROW_PREDICT: if (has_r) pending_results.push_back(r);
			ROW_RESULT:  pending_results.push_back(row.res);
			default:     ;
		endcase
		events_accepted++;
	endtask

	// Sender bursts: random length, random gaps, sometimes back to back.
	task automatic pace();
		int unsigned gap;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
		if (gap != 0) begin
			release_input();
			repeat (gap) @(posedge clk);
		end
		burst_left = ($urandom_range(4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
	endtask

	task automatic drain_results();
		release_input();
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	// Events with no result may still be in flight once the last result is
	// in, so give the sequencer time before touching the registers.
	task automatic settle_idle();
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input logic [7:0] s, input logic [7:0] p, input logic [2:0] l);
		cfg_wr_en <= 1'b1;
		cfg_index <= crsq_pkg::CFG_STATUS_CODE;
		cfg_data  <= s;
		@(posedge clk);
		status_code = s;
		cfg_index <= crsq_pkg::CFG_POSITION_CODE;
		cfg_data  <= p;
		@(posedge clk);
		position_code = p;
		cfg_index <= crsq_pkg::CFG_RETRY_LIMIT;
		cfg_data  <= {5'd0, l};
		@(posedge clk);
		retry_max = l;
		cfg_wr_en <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Receiver: stall pattern of its own, plus one long hold on request
	// ------------------------------------------------------------------

	initial begin : receiver
		int unsigned mode;
		int unsigned mode_left;
		int unsigned held;
		mode = 0;
		mode_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				// Long hold: the output register fills and the block backs up
				// its input while the sender keeps offering.
				hold_request = 1'b0;
				out_stall <= 1'b1;
				held = 0;
				while (held < LONG_HOLD_CYCLES) begin
					@(posedge clk);
					held++;
				end
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(2);
					mode_left = $urandom_range(5, 80);
				end
				mode_left--;
				case (mode)
					0:       out_stall <= 1'b0;
					1:       out_stall <= ($urandom_range(99) < 30);
					default: out_stall <= ($urandom_range(99) < 70);
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------

	task automatic check_field(input string name, input int unsigned want_v,
			input int unsigned got_v);
		if (want_v !== got_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin : result_monitor
		send_result_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result transaction: action %0d, command %0d",
					action, send_command);
				errors++;
			end else begin
				want = pending_results.pop_front();
				check_field("action", want.act, action);
				check_field("send_command", want.cmd, send_command);
				check_field("send_temperature", want.temp, send_temperature);
				check_field("temperature_present", want.present, temperature_present);
				check_field("attempts_so_far", want.attempts, attempts_so_far);
				check_field("queue_level", want.level, queue_level);
				check_field("gave_up", want.gave, gave_up);
				results_checked++;
				if (want.act == crsq_pkg::ACT_DROPPED)
					dropped_seen++;
				if (want.gave)
					gave_up_seen++;
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog
	// ------------------------------------------------------------------

	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("coalescing_retry_send_queue_top regression: fail");
		$finish;
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------

	initial begin : stimulus
		int unsigned accepted_in_phase;
		int unsigned push_pct;
		int unsigned drain;

		// Directed rows, run under the reset register values
		// (status 0, position 1, retry limit 5).
		// Link events on an empty queue: nothing happens.
		add_row(crsq_pkg::KIND_DONE,  8'h00, 0, ROW_NO_RESULT, '0);
		add_row(crsq_pkg::KIND_FAIL,  8'h00, 0, ROW_NO_RESULT, '0);
		add_row(crsq_pkg::KIND_TIMER, 8'h00, 0, ROW_NO_RESULT, '0);
		// First push into an empty queue is sent straight away.
		add_row(crsq_pkg::KIND_PUSH, 8'hFF, 999, ROW_RESULT,
			mk_result(crsq_pkg::ACT_SEND, 8'hFF, 999, 1'b1, 0, 1, 1'b0));
		// Status request appended, then a position request folds into it.
		add_row(crsq_pkg::KIND_PUSH, 8'h00, -1, ROW_NO_RESULT, '0);
		add_row(crsq_pkg::KIND_PUSH, 8'h01, 0, ROW_NO_RESULT, '0);
		add_row(crsq_pkg::KIND_PUSH, 8'h80, -1, ROW_NO_RESULT, '0);
		add_row(crsq_pkg::KIND_PUSH, 8'h7F, 512, ROW_NO_RESULT, '0);
		// Full: plain push is dropped and reports the head.
		add_row(crsq_pkg::KIND_PUSH, 8'h55, 0, ROW_RESULT,
			mk_result(crsq_pkg::ACT_DROPPED, 8'hFF, 999, 1'b1, 0, 4, 1'b0));
		// Full, but a request still folds into the queued one.
		add_row(crsq_pkg::KIND_PUSH, 8'h00, 5, ROW_NO_RESULT, '0);
		add_row(crsq_pkg::KIND_TIMER, 8'h00, 0, ROW_RESULT,
			mk_result(crsq_pkg::ACT_SEND, 8'hFF, 999, 1'b1, 0, 4, 1'b0));
		// Drain by send-done; the last one leaves the queue empty.
		add_row(crsq_pkg::KIND_DONE, 8'h00, 0, ROW_PREDICT, '0);
		add_row(crsq_pkg::KIND_DONE, 8'h00, 0, ROW_PREDICT, '0);
		add_row(crsq_pkg::KIND_DONE, 8'h00, 0, ROW_PREDICT, '0);
		add_row(crsq_pkg::KIND_DONE, 8'h00, 0, ROW_NO_RESULT, '0);
		add_row(crsq_pkg::KIND_PUSH, 8'hAA, 0, ROW_RESULT,
			mk_result(crsq_pkg::ACT_SEND, 8'hAA, 0, 1'b1, 0, 1, 1'b0));
		// Retry up to the limit, then the lone entry is abandoned silently.
		add_row(crsq_pkg::KIND_FAIL, 8'h00, 0, ROW_RESULT,
			mk_result(crsq_pkg::ACT_RETRY_WAIT, 8'hAA, 0, 1'b1, 1, 1, 1'b0));
		repeat (4) add_row(crsq_pkg::KIND_FAIL, 8'h00, 0, ROW_PREDICT, '0);
		add_row(crsq_pkg::KIND_FAIL, 8'h00, 0, ROW_NO_RESULT, '0);

		phase_status[PHASES - 1]   = 8'($urandom_range(255));
		phase_position[PHASES - 1] = 8'($urandom_range(255));
		phase_limit[PHASES - 1]    = 3'($urandom_range(7));

		// Single reset at the start of the run.
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			offer(directed_rows[i]);
			pace();
		end

		// Random phases, each under its own register setting.
		for (int ph = 0; ph < PHASES; ph++) begin
			settle_idle();
			configure(phase_status[ph], phase_position[ph], phase_limit[ph]);
			accepted_in_phase = 0;
			push_pct = 50;
			// Third phase: long receiver hold while the sender keeps going.
			if (ph == 2)
				hold_request = 1'b1;
			while (accepted_in_phase < RANDOM_PER_PHASE) begin
				// Push share drifts so the queue swings between empty and full.
				if (accepted_in_phase % 40 == 0)
					push_pct = $urandom_range(20, 70);
				offer(random_event(push_pct));
				accepted_in_phase++;
				// Fourth phase: sender stops mid-way until every result is in.
				if (ph == 3 && accepted_in_phase == RANDOM_PER_PHASE / 2)
					drain_results();
				pace();
			end
		end

		release_input();
		drain = 0;
		while (pending_results.size() != 0 && drain < DRAIN_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d expected result transactions never arrived",
				pending_results.size());
			errors++;
		end

		$display("Ran %0d transactions (directed plus %0d random phases), %0d results checked.",
			events_accepted, PHASES, results_checked);
		$display("Saw %0d dropped pushes and %0d abandoned heads; %0d mismatches.",
			dropped_seen, gave_up_seen, errors);
		if (errors == 0) begin
			$display("coalescing_retry_send_queue_top regression: pass");
		end else begin
			$display("coalescing_retry_send_queue_top regression: fail");
		end
		$finish;
	end

endmodule
